/* design/assert_macros.svh */
// Assertion macros shared by the tag engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sactlr_pkg.sv */
// Shared types and constants of the cache tag and replacement engine.
package sactlr_pkg;

    // Default geometry
    localparam int LINE_OFFSET_BITS_DEF = 4;
    localparam int SET_INDEX_BITS_DEF   = 6;
    localparam int WAYS_DEF             = 4;

    // Input action codes
    localparam logic [1:0] ACT_ACCESS     = 2'd0;
    localparam logic [1:0] ACT_FLUSH_ALL  = 2'd1;
    localparam logic [1:0] ACT_FLUSH_LINE = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOOKUP,
        OP_BYPASS,
        OP_FLUSH_ALL,
        OP_FLUSH_LINE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
    } t_item;

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

/* design/set_assoc_cache_tag_lfsr_replace_unit.sv */
// Top level of the set-associative cache tag engine with LFSR replacement.
//
//  channel   direction  handshake                   payload
//  in        to block   i_in_valid / o_in_stall     i_action, i_addr
//  out       from block o_out_valid / i_out_stall   o_hit, o_refill_request,
//                                                    o_refill_line_addr, o_way_used, o_bypass
//  config    to block   psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// In the back end an item first has the tag and valid rows of its set read, then it is
// compared, updates the stores and loads the result register once that register is free.
// A flush-all item is followed by a sweep that clears the valid row of every set (64 by default).
// After reset the same sweep runs before the first item is taken; o_in_stall is high.
// A two-entry queue lets the input keep filling while a result waits on i_out_stall.
`include "assert_macros.svh"

module set_assoc_cache_tag_lfsr_replace_unit import sactlr_pkg::*; #(
    parameter int LINE_OFFSET_BITS = LINE_OFFSET_BITS_DEF,
    parameter int SET_INDEX_BITS   = SET_INDEX_BITS_DEF,
    parameter int WAYS             = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_addr,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic        o_refill_request,
    output logic [31:0] o_refill_line_addr,
    output logic [1:0]  o_way_used,
    output logic        o_bypass,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_CACHE_ENABLE = 1'b0;

    logic  r_cache_enable;
    logic  cfg_wr;
    logic  q_push, q_pop, q_avail, q_full;
    logic  back_clearing;
    t_item front_item, q_item;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_CACHE_ENABLE)) begin
            r_cache_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_CACHE_ENABLE) ? {31'd0, r_cache_enable} : 32'd0;

    sactlr_front u_front (
        .i_in_valid     (i_in_valid),
        .i_action       (i_action),
        .i_addr         (i_addr),
        .i_cache_enable (r_cache_enable),
        .i_q_full       (q_full),
        .i_clearing     (back_clearing),
        .o_in_stall     (o_in_stall),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    sactlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_avail (q_avail),
        .o_full  (q_full)
    );

    sactlr_back #(
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
        .SET_INDEX_BITS   (SET_INDEX_BITS),
        .WAYS             (WAYS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_avail       (q_avail),
        .i_item             (q_item),
        .o_pop              (q_pop),
        .o_clearing         (back_clearing),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_hit              (o_hit),
        .o_refill_request   (o_refill_request),
        .o_refill_line_addr (o_refill_line_addr),
        .o_way_used         (o_way_used),
        .o_bypass           (o_bypass)
    );

    `ASSERT_IMPLIES(a_sweep_blocks_input, back_clearing, o_in_stall, "item taken during sweep")

endmodule

/* design/sactlr_front.sv */
// Front end: accepts items, classifies them and pushes them into the queue.
module sactlr_front import sactlr_pkg::*; (
    input  logic        i_in_valid,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_addr,
    input  logic        i_cache_enable,
    input  logic        i_q_full,
    input  logic        i_clearing,
    output logic        o_in_stall,
    output logic        o_push,
    output t_item       o_item
);

    t_op cls_op;

    // Hold off while the queue is full or the valid store is being swept
    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    // Decode action, folding in the enable register
    always_comb begin
        unique case (i_action)
            ACT_ACCESS:     cls_op = i_cache_enable ? OP_LOOKUP : OP_BYPASS;
            ACT_FLUSH_ALL:  cls_op = OP_FLUSH_ALL;
            ACT_FLUSH_LINE: cls_op = OP_FLUSH_LINE;
            default:        cls_op = OP_NOP;
        endcase
    end

    assign o_item.op   = cls_op;
    assign o_item.addr = i_addr;

endmodule

/* design/sactlr_queue.sv */
// Short FIFO of classified items between front and back.
`include "assert_macros.svh"

module sactlr_queue import sactlr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output logic   o_avail,
    output logic   o_full
);

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_IMPLIES(a_q_no_overflow, i_push, !o_full, "queue push while full")
    `ASSERT_IMPLIES(a_q_no_underflow, i_pop, o_avail, "queue pop while empty")

endmodule

/* design/sactlr_back.sv */
// Back end: tag and valid stores, LFSR victim choice, flushes and result register.
`include "assert_macros.svh"

module sactlr_back import sactlr_pkg::*; #(
    parameter int LINE_OFFSET_BITS = LINE_OFFSET_BITS_DEF,
    parameter int SET_INDEX_BITS   = SET_INDEX_BITS_DEF,
    parameter int WAYS             = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_avail,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_clearing,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_hit,
    output logic        o_refill_request,
    output logic [31:0] o_refill_line_addr,
    output logic [1:0]  o_way_used,
    output logic        o_bypass
);

    localparam int TAG_W    = 32 - LINE_OFFSET_BITS - SET_INDEX_BITS;
    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // LFSR feedback taps
    localparam int TAP_A = 7;
    localparam int TAP_B = 3;
    localparam int TAP_C = 2;
    localparam int TAP_D = 1;

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [SET_INDEX_BITS-1:0]  r_clr_idx;
    logic [7:0]                 r_lfsr;

    // Current item, split into its address parts
    t_op                        r_op;
    logic [TAG_W-1:0]           r_tag;
    logic [SET_INDEX_BITS-1:0]  r_set;
    logic [31:0]                r_line;

    // Stores and their registered read data
    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem [NUM_SETS];
    logic [WAYS-1:0]            r_vld_mem [NUM_SETS];
    logic [WAYS-1:0][TAG_W-1:0] r_tag_rd;
    logic [WAYS-1:0]            r_vld_rd;

    // Result register
    logic                       r_out_valid;
    logic                       r_hit;
    logic                       r_refill;
    logic [31:0]                r_refill_line;
    logic [1:0]                 r_way;
    logic                       r_bypass;

    logic [WAYS-1:0]            hit_vec;
    logic                       any_hit;
    logic [WAY_W-1:0]           hit_way;
    logic [7:0]                 lfsr_nxt;
    logic [3:0]                 vic_rem;
    logic [WAY_W-1:0]           victim;
    logic                       out_free;
    logic                       exec_go;
    logic                       is_lookup;
    logic                       is_miss;
    logic                       vld_we;
    logic [WAYS-1:0]            vld_wdata;
    logic [SET_INDEX_BITS-1:0]  in_set;

    assign in_set = i_item.addr[LINE_OFFSET_BITS +: SET_INDEX_BITS];

    // Tag compare across the ways of the set
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = r_vld_rd[w] && (r_tag_rd[w] == r_tag);
        end
    end
    assign any_hit = |hit_vec;

    // Lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    // LFSR step and victim (bits 3:1 of the new value, reduced modulo the way count)
    assign lfsr_nxt = {r_lfsr[6:0],
                       ~(r_lfsr[TAP_A] ^ r_lfsr[TAP_B] ^ r_lfsr[TAP_C] ^ r_lfsr[TAP_D])};

    always_comb begin
        vic_rem = {1'b0, lfsr_nxt[3:1]};
        for (int i = 0; i < 8; i++) begin
            if (vic_rem >= 4'(WAYS)) begin
                vic_rem = vic_rem - 4'(WAYS);
            end
        end
        victim = WAY_W'(vic_rem);
    end

    // Control decode
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_go    = (r_state == S_EXEC) && out_free;
    assign is_lookup  = (r_op == OP_LOOKUP);
    assign is_miss    = is_lookup && !any_hit;
    assign o_pop      = (r_state == S_IDLE) && i_item_avail;
    assign o_clearing = (r_state == S_CLEAR);

    // Valid row update: install on miss, drop matches on line flush
    always_comb begin
        vld_we    = 1'b0;
        vld_wdata = r_vld_rd;
        if (is_miss) begin
            vld_we    = 1'b1;
            vld_wdata = r_vld_rd | (WAYS'(1) << victim);
        end else if (r_op == OP_FLUSH_LINE) begin
            vld_we    = 1'b1;
            vld_wdata = r_vld_rd & ~hit_vec;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = (r_op == OP_FLUSH_ALL) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_lfsr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (exec_go && is_miss) begin
                r_lfsr <= lfsr_nxt;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture of the popped item
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_item.op;
            r_tag  <= i_item.addr[31 -: TAG_W];
            r_set  <= in_set;
            r_line <= {i_item.addr[31:LINE_OFFSET_BITS], LINE_OFFSET_BITS'(0)};
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_hit         <= is_lookup && any_hit;
            r_refill      <= is_miss;
            r_refill_line <= is_miss ? r_line : 32'd0;
            r_bypass      <= (r_op == OP_BYPASS);
            if (is_lookup) begin
                r_way <= any_hit ? 2'(hit_way) : 2'(victim);
            end else begin
                r_way <= 2'd0;
            end
        end
    end

    // Tag store
    always_ff @(posedge i_clk) begin
        if (exec_go && is_miss) begin
            r_tag_mem[r_set][victim] <= r_tag;
        end
        if (o_pop) begin
            r_tag_rd <= r_tag_mem[in_set];
        end
    end

    // Valid store, swept clean after reset and on flush-all
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_vld_mem[r_clr_idx] <= '0;
        end else if (exec_go && vld_we) begin
            r_vld_mem[r_set] <= vld_wdata;
        end
        if (o_pop) begin
            r_vld_rd <= r_vld_mem[in_set];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_refill_request   = r_refill;
    assign o_refill_line_addr = r_refill_line;
    assign o_way_used         = r_way;
    assign o_bypass           = r_bypass;

    `ASSERT_IMPLIES(a_single_match, r_state == S_EXEC, $onehot0(hit_vec), "tag held in two ways")
    `ASSERT_NEXT(a_lfsr_on_miss, exec_go && is_miss, r_lfsr == $past(lfsr_nxt), "lfsr not stepped")

endmodule
